>>> hw/rtl/gpp_pkg.sv
`timescale 1ns / 1ps

package gpp_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int PIX_W      = 8;
    localparam int MASK_W     = 8;
    localparam int ROW_N_W    = 17;
    localparam int ROW_R_W    = 20;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register reset values
    localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 16'd1;
    localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 16'd1;
    localparam logic [MASK_W-1:0]  MASK_CLEAR_RST   = 8'd0;
    localparam logic [MASK_W-1:0]  MASK_OPAQUE_RST  = 8'd255;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH       = 3'd0,
        REG_FRAME_HEIGHT      = 3'd1,
        REG_INTERLACE_ON      = 3'd2,
        REG_TRANSPARENCY_ON   = 3'd3,
        REG_TRANSPARENT_INDEX = 3'd4,
        REG_MASK_CLEAR_VALUE  = 3'd5,
        REG_MASK_OPAQUE_VALUE = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] frame_width;
        logic [COORD_W-1:0] frame_height;
        logic               interlace_on;
        logic               transparency_on;
        logic [PIX_W-1:0]   transparent_index;
        logic [MASK_W-1:0]  mask_clear_value;
        logic [MASK_W-1:0]  mask_opaque_value;
    } t_cfg;

    // One classified pixel on its way from front to back
    typedef struct packed {
        logic [PIX_W-1:0]   pixel_index;
        logic [COORD_W-1:0] line;
        logic [COORD_W-1:0] column;
        logic               adv;
        logic               first;
        logic               overflow;
        logic               color_write;
        logic               mask_write;
        logic               mask_clear;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line;
    } t_front_status;

endpackage

>>> hw/rtl/gpp_if.sv
`timescale 1ns / 1ps

// Pixel channel into the block
interface gpp_pix_if import gpp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_index;
    logic             first_of_frame;

    modport source (output valid, pixel_index, first_of_frame, input ready);
    modport sink   (input valid, pixel_index, first_of_frame, output ready);
endinterface

// Placement channel out of the block
interface gpp_place_if import gpp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               color_write;
    logic [PIX_W-1:0]   color_value;
    logic               mask_write;
    logic [MASK_W-1:0]  mask_value;
    logic               overflow;

    modport source (output valid, row, column, color_write, color_value, mask_write,
                    mask_value, overflow, input ready);
    modport sink   (input valid, row, column, color_write, color_value, mask_write,
                    mask_value, overflow, output ready);
endinterface

>>> hw/rtl/gpp_queue.sv
`timescale 1ns / 1ps

module gpp_queue import gpp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_push_entry,
    input  logic      i_pop,
    output t_q_entry  o_head,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/gpp_front.sv
`timescale 1ns / 1ps

module gpp_front import gpp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gpp_pix_if.sink       i_pix,
    input  t_cfg          i_cfg,
    input  t_q_status     i_q_status,
    output logic          o_push,
    output t_q_entry      o_push_entry,
    output t_front_status o_status
);

    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_line;
    logic [COORD_W-1:0] n_col;
    logic [COORD_W-1:0] n_line;

    logic [COORD_W-1:0] w_col_base;
    logic [COORD_W-1:0] w_line_base;
    logic [COORD_W-1:0] w_col_now;
    logic               w_adv;
    logic               w_ovf;
    logic               w_transp;

    assign i_pix.ready = !i_q_status.full;
    assign o_push      = i_pix.valid && i_pix.ready;
    assign o_status.column = r_col;
    assign o_status.line   = r_line;

    // Step the position and classify the pixel
    always_comb begin
        w_col_base  = i_pix.first_of_frame ? '0 : r_col;
        w_line_base = i_pix.first_of_frame ? '0 : r_line;
        w_adv       = (w_col_base >= i_cfg.frame_width);
        n_line      = w_adv ? w_line_base + COORD_W'(1) : w_line_base;
        w_col_now   = w_adv ? '0 : w_col_base;
        w_ovf       = (n_line >= i_cfg.frame_height);
        n_col       = w_ovf ? w_col_now : w_col_now + COORD_W'(1);
        w_transp    = i_cfg.transparency_on && (i_pix.pixel_index == i_cfg.transparent_index);

        o_push_entry.pixel_index = i_pix.pixel_index;
        o_push_entry.line        = n_line;
        o_push_entry.column      = w_ovf ? '0 : w_col_now;
        o_push_entry.adv         = w_adv;
        o_push_entry.first       = i_pix.first_of_frame;
        o_push_entry.overflow    = w_ovf;
        o_push_entry.color_write = !w_ovf && !w_transp;
        o_push_entry.mask_write  = !w_ovf && i_cfg.transparency_on;
        o_push_entry.mask_clear  = w_transp;
    end

    // Hold position between transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else if (o_push) begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

endmodule

>>> hw/rtl/gpp_back.sv
`timescale 1ns / 1ps

module gpp_back import gpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_q_status  i_q_status,
    input  t_q_entry   i_head,
    output logic       o_pop,
    gpp_place_if.source o_place
);

    typedef struct packed {
        t_q_entry           entry;
        logic [ROW_N_W-1:0] n;
        logic [ROW_R_W-1:0] r;
        logic               done;
    } t_row_stage;

    // One pass of the interlace search: skip the rows of the earlier pass
    function automatic t_row_stage row_level(input t_row_stage s, input logic [COORD_W-1:0] h,
                                             input logic [ROW_N_W-1:0] skip,
                                             input logic [1:0] sh,
                                             input logic [ROW_R_W-1:0] ofs);
        t_row_stage         o;
        logic [ROW_N_W-1:0] n;
        logic [ROW_R_W-1:0] r;
        o = s;
        n = s.n - skip;
        r = ({3'b000, n} << sh) + ofs;
        if (!s.done) begin
            o.n    = n;
            o.r    = r;
            o.done = (r < {4'b0000, h});
        end
        return o;
    endfunction

    logic [ROW_N_W-1:0] w_skip8;
    logic [ROW_N_W-1:0] w_skip4;
    logic [ROW_N_W-1:0] w_skip2;
    t_row_stage         w_seed;
    t_row_stage         w_fin;
    logic [COORD_W-1:0] w_row_sel;
    logic [MASK_W-1:0]  w_mask_sel;

    t_row_stage         r_s1, r_s2, r_s3;
    logic               r_s1_valid, r_s2_valid, r_s3_valid;
    logic               w_s1_free, w_s2_free, w_s3_free, w_out_free;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_column;
    logic               r_color_write;
    logic [PIX_W-1:0]   r_color_value;
    logic               r_mask_write;
    logic [MASK_W-1:0]  r_mask_value;
    logic               r_overflow;
    logic [COORD_W-1:0] r_cur_row;

    // Rows in each earlier interlace pass
    assign w_skip8 = ({1'b0, i_cfg.frame_height} + ROW_N_W'(7)) >> 3;
    assign w_skip4 = ({1'b0, i_cfg.frame_height} + ROW_N_W'(3)) >> 3;
    assign w_skip2 = ({1'b0, i_cfg.frame_height} + ROW_N_W'(1)) >> 2;

    // Stall chain from the output register back to the queue
    assign w_out_free = !r_out_valid || o_place.ready;
    assign w_s3_free  = !r_s3_valid || w_out_free;
    assign w_s2_free  = !r_s2_valid || w_s3_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign o_pop      = !i_q_status.empty && w_s1_free;

    always_comb begin
        w_seed.entry = i_head;
        w_seed.n     = {1'b0, i_head.line};
        w_seed.r     = '0;
        w_seed.done  = 1'b0;
        w_fin        = row_level(r_s3, i_cfg.frame_height, w_skip2, 2'd1, ROW_R_W'(1));

        // Pick the row: a new line recomputes it, a frame start clears it
        if (r_s3.entry.adv) begin
            w_row_sel = i_cfg.interlace_on ? w_fin.r[COORD_W-1:0] : r_s3.entry.line;
        end else if (r_s3.entry.first) begin
            w_row_sel = '0;
        end else begin
            w_row_sel = r_cur_row;
        end

        w_mask_sel = r_s3.entry.mask_clear ? i_cfg.mask_clear_value : i_cfg.mask_opaque_value;
    end

    // Row search pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_s1 <= row_level(w_seed, i_cfg.frame_height, '0, 2'd3, '0);
        end
        if (w_s2_free) begin
            r_s2 <= row_level(r_s1, i_cfg.frame_height, w_skip8, 2'd3, ROW_R_W'(4));
        end
        if (w_s3_free) begin
            r_s3 <= row_level(r_s2, i_cfg.frame_height, w_skip4, 2'd2, ROW_R_W'(2));
        end
        if (w_out_free && r_s3_valid) begin
            r_row         <= r_s3.entry.overflow ? '0 : w_row_sel;
            r_column      <= r_s3.entry.column;
            r_color_write <= r_s3.entry.color_write;
            r_color_value <= r_s3.entry.color_write ? r_s3.entry.pixel_index : '0;
            r_mask_write  <= r_s3.entry.mask_write;
            r_mask_value  <= r_s3.entry.mask_write ? w_mask_sel : '0;
            r_overflow    <= r_s3.entry.overflow;
        end
    end

    // Advance valids and hold the current row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_row   <= '0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= o_pop;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s3_valid;
                if (r_s3_valid) begin
                    r_cur_row <= w_row_sel;
                end
            end
        end
    end

    assign o_place.valid       = r_out_valid;
    assign o_place.row         = r_row;
    assign o_place.column      = r_column;
    assign o_place.color_write = r_color_write;
    assign o_place.color_value = r_color_value;
    assign o_place.mask_write  = r_mask_write;
    assign o_place.mask_value  = r_mask_value;
    assign o_place.overflow    = r_overflow;

endmodule

>>> hw/rtl/gif_pixel_placement_core.sv
`timescale 1ns / 1ps
// Path: a pixel goes through the queue, row stages s1 to s3 and the output register.
// Throughput: one pixel per cycle unless the queue fills or the output is not ready; the
// position counters step once per transfer; the four-stage interlace pipeline can stall.
// Reset: synchronous, active low; clears position counters, queue, pipeline valids and
// the current row, and returns all configuration registers to their defaults.

module gif_pixel_placement_core import gpp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gpp_pix_if.sink               i_pix,
    gpp_place_if.source           o_place,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg          r_cfg;
    t_q_status     w_q_status;
    t_q_entry      w_push_entry;
    t_q_entry      w_head;
    t_front_status w_front_status;
    logic          w_push;
    logic          w_pop;
    logic          w_cfg_wr;
    t_reg_idx      w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width       <= FRAME_WIDTH_RST;
            r_cfg.frame_height      <= FRAME_HEIGHT_RST;
            r_cfg.interlace_on      <= 1'b0;
            r_cfg.transparency_on   <= 1'b0;
            r_cfg.transparent_index <= '0;
            r_cfg.mask_clear_value  <= MASK_CLEAR_RST;
            r_cfg.mask_opaque_value <= MASK_OPAQUE_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_FRAME_WIDTH:       r_cfg.frame_width       <= pwdata[COORD_W-1:0];
                REG_FRAME_HEIGHT:      r_cfg.frame_height      <= pwdata[COORD_W-1:0];
                REG_INTERLACE_ON:      r_cfg.interlace_on      <= pwdata[0];
                REG_TRANSPARENCY_ON:   r_cfg.transparency_on   <= pwdata[0];
                REG_TRANSPARENT_INDEX: r_cfg.transparent_index <= pwdata[PIX_W-1:0];
                REG_MASK_CLEAR_VALUE:  r_cfg.mask_clear_value  <= pwdata[MASK_W-1:0];
                REG_MASK_OPAQUE_VALUE: r_cfg.mask_opaque_value <= pwdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (w_reg_idx)
            REG_FRAME_WIDTH:       prdata = APB_DATA_W'(r_cfg.frame_width);
            REG_FRAME_HEIGHT:      prdata = APB_DATA_W'(r_cfg.frame_height);
            REG_INTERLACE_ON:      prdata = APB_DATA_W'(r_cfg.interlace_on);
            REG_TRANSPARENCY_ON:   prdata = APB_DATA_W'(r_cfg.transparency_on);
            REG_TRANSPARENT_INDEX: prdata = APB_DATA_W'(r_cfg.transparent_index);
            REG_MASK_CLEAR_VALUE:  prdata = APB_DATA_W'(r_cfg.mask_clear_value);
            REG_MASK_OPAQUE_VALUE: prdata = APB_DATA_W'(r_cfg.mask_opaque_value);
            default:               prdata = '0;
        endcase
    end

    gpp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_cfg        (r_cfg),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_push_entry (w_push_entry),
        .o_status     (w_front_status)
    );

    gpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_entry (w_push_entry),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_status     (w_q_status)
    );

    gpp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (w_q_status),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_place    (o_place)
    );

    // A frame start with a real frame leaves the front one pixel into line zero
    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && i_pix.first_of_frame && r_cfg.frame_width != '0 &&
         r_cfg.frame_height != '0)
        |=> (w_front_status.column == COORD_W'(1) && w_front_status.line == '0))
        else $error("front position wrong after frame start");

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue both full and empty");

    a_overflow_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_place.valid && o_place.overflow)
        |-> (!o_place.color_write && !o_place.mask_write &&
             o_place.row == '0 && o_place.column == '0))
        else $error("overflow pixel still writes");

    a_mask_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_place.valid && o_place.mask_write && !o_place.color_write)
        |-> (r_cfg.transparency_on && o_place.mask_value == r_cfg.mask_clear_value))
        else $error("mask-only write without transparent value");

endmodule

>>> tb/tb_gif_pixel_placement_core.sv
`timescale 1ns / 1ps

module tb_gif_pixel_placement_core;
    import gpp_pkg::*;

    localparam int TOTAL_PIX      = 1850;
    localparam int FRAME_CAP      = 160;
    localparam int SETTLE_CYCLES  = 8;
    localparam int SINK_HOLD_LEN  = 300;
    localparam int LIMIT_CYCLES   = 400000;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_index;
        logic             first;
    } pix_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic               color_write;
        logic [PIX_W-1:0]   color_value;
        logic               mask_write;
        logic [MASK_W-1:0]  mask_value;
        logic               overflow;
    } placement_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gpp_pix_if   pix_ch ();
    gpp_place_if place_ch ();

    gif_pixel_placement_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_place (place_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register copy and position state used for prediction
    t_cfg                 cfg_mirror;
    logic [COORD_W-1:0]   pos_column;
    logic [COORD_W-1:0]   pos_line;
    logic [ROW_N_W-1:0]   pos_row;

    pix_item_t            pending_pix_q[$];
    placement_t           placement_q[$];
    pix_item_t            next_pix;

    int                   src_idle_pct  = 21;
    int                   sink_idle_pct = 71;
    bit                   sink_hold_req = 1'b0;
    int                   sink_hold_left = 0;
    int                   pix_pushed = 0;
    int                   push_limit = TOTAL_PIX;
    int                   fail_count = 0;
    int                   cycle_count = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Row of a sequential line under the four-pass interlace order
    function automatic logic [ROW_N_W-1:0] interlace_row(input logic [COORD_W-1:0] line,
                                                         input logic [COORD_W-1:0] height);
        int n;
        int hh;
        int r;
        n  = line;
        hh = height;
        r  = n * 8;
        if (r >= hh) begin
            n = n - (hh + 7) / 8;
            r = n * 8 + 4;
            if (r >= hh) begin
                n = n - (hh + 3) / 8;
                r = n * 4 + 2;
                if (r >= hh) begin
                    n = n - (hh + 1) / 4;
                    r = n * 2 + 1;
                end
            end
        end
        if (r < 0) begin
            r = 0;
        end
        return r[ROW_N_W-1:0];
    endfunction

    // Advance the position by one pixel and work out its placement
    function automatic placement_t place_pixel(input logic [PIX_W-1:0] pix, input logic first);
        placement_t res;
        res = '0;
        if (first) begin
            pos_column = '0;
            pos_line   = '0;
            pos_row    = '0;
        end
        if (pos_column >= cfg_mirror.frame_width) begin
            pos_line   = pos_line + COORD_W'(1);
            pos_row    = cfg_mirror.interlace_on ?
                         interlace_row(pos_line, cfg_mirror.frame_height) : {1'b0, pos_line};
            pos_column = '0;
        end
        if (pos_line >= cfg_mirror.frame_height) begin
            res.overflow = 1'b1;
            return res;
        end
        res.row    = pos_row[COORD_W-1:0];
        res.column = pos_column;
        if (cfg_mirror.transparency_on && pix == cfg_mirror.transparent_index) begin
            res.mask_write = 1'b1;
            res.mask_value = cfg_mirror.mask_clear_value;
        end else begin
            res.color_write = 1'b1;
            res.color_value = pix;
            if (cfg_mirror.transparency_on) begin
                res.mask_write = 1'b1;
                res.mask_value = cfg_mirror.mask_opaque_value;
            end
        end
        pos_column = pos_column + COORD_W'(1);
        return res;
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_field_mask(input t_reg_idx idx);
        case (idx)
            REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
                return 32'h0000_FFFF;
            end
            REG_INTERLACE_ON, REG_TRANSPARENCY_ON: begin
                return 32'h0000_0001;
            end
            default: begin
                return 32'h0000_00FF;
            end
        endcase
    endfunction

    // Pixel driver: present the next pending pixel, record each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                placement_q.push_back(place_pixel(pix_ch.pixel_index, pix_ch.first_of_frame));
            end
            if (!pix_ch.valid || pix_ch.ready) begin
                if (pending_pix_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_pix = pending_pix_q.pop_front();
                    pix_ch.valid          <= 1'b1;
                    pix_ch.pixel_index    <= next_pix.pixel_index;
                    pix_ch.first_of_frame <= next_pix.first;
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_placement(input placement_t exp);
        if (place_ch.row !== exp.row) begin
            $error("row: expected %0d, got %0d", exp.row, place_ch.row);
            fail_count++;
        end
        if (place_ch.column !== exp.column) begin
            $error("column: expected %0d, got %0d", exp.column, place_ch.column);
            fail_count++;
        end
        if (place_ch.color_write !== exp.color_write) begin
            $error("color_write: expected %0d, got %0d", exp.color_write, place_ch.color_write);
            fail_count++;
        end
        if (place_ch.color_value !== exp.color_value) begin
            $error("color_value: expected %0d, got %0d", exp.color_value, place_ch.color_value);
            fail_count++;
        end
        if (place_ch.mask_write !== exp.mask_write) begin
            $error("mask_write: expected %0d, got %0d", exp.mask_write, place_ch.mask_write);
            fail_count++;
        end
        if (place_ch.mask_value !== exp.mask_value) begin
            $error("mask_value: expected %0d, got %0d", exp.mask_value, place_ch.mask_value);
            fail_count++;
        end
        if (place_ch.overflow !== exp.overflow) begin
            $error("overflow: expected %0d, got %0d", exp.overflow, place_ch.overflow);
            fail_count++;
        end
    endtask

    // Placement monitor: compare each transfer, drive ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            place_ch.ready <= 1'b0;
        end else begin
            if (place_ch.valid && place_ch.ready) begin
                if (placement_q.size() == 0) begin
                    $error("placement transfer with no pixel outstanding");
                    fail_count++;
                end else begin
                    check_placement(placement_q.pop_front());
                end
            end
            if (sink_hold_req) begin
                sink_hold_left = SINK_HOLD_LEN;
                sink_hold_req  = 1'b0;
            end
            if (sink_hold_left != 0) begin
                sink_hold_left--;
                place_ch.ready <= 1'b0;
            end else begin
                place_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("gif_pixel_placement_core regression: fail");
            $finish;
        end
    end

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic first);
        pending_pix_q.push_back('{pixel_index: pix, first: first});
        pix_pushed++;
    endtask

    // Hold until every pixel has been placed and the block has settled
    task automatic wait_drained();
        while (pending_pix_q.size() != 0 || pix_ch.valid || placement_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register (junk in the unused upper bits), then read it back
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] fmask;
        logic [APB_DATA_W-1:0] expected;
        fmask    = reg_field_mask(idx);
        expected = val & fmask;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~fmask) | expected;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:       cfg_mirror.frame_width       = expected[COORD_W-1:0];
            REG_FRAME_HEIGHT:      cfg_mirror.frame_height      = expected[COORD_W-1:0];
            REG_INTERLACE_ON:      cfg_mirror.interlace_on      = expected[0];
            REG_TRANSPARENCY_ON:   cfg_mirror.transparency_on   = expected[0];
            REG_TRANSPARENT_INDEX: cfg_mirror.transparent_index = expected[PIX_W-1:0];
            REG_MASK_CLEAR_VALUE:  cfg_mirror.mask_clear_value  = expected[MASK_W-1:0];
            default:               cfg_mirror.mask_opaque_value = expected[MASK_W-1:0];
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== expected) begin
            $error("register %s: expected %0h, got %0h", idx.name(), expected, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                             input logic il, input logic tr, input logic [PIX_W-1:0] ti,
                             input logic [MASK_W-1:0] mc, input logic [MASK_W-1:0] mo);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, APB_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, APB_DATA_W'(h));
        write_reg(REG_INTERLACE_ON, APB_DATA_W'(il));
        write_reg(REG_TRANSPARENCY_ON, APB_DATA_W'(tr));
        write_reg(REG_TRANSPARENT_INDEX, APB_DATA_W'(ti));
        write_reg(REG_MASK_CLEAR_VALUE, APB_DATA_W'(mc));
        write_reg(REG_MASK_OPAQUE_VALUE, APB_DATA_W'(mo));
    endtask

    // Bias toward the transparent index so both mask paths get traffic
    function automatic logic [PIX_W-1:0] random_pixel();
        if ($urandom_range(3) == 0) begin
            return cfg_mirror.transparent_index;
        end
        return PIX_W'($urandom_range(255));
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return MASK_W'($urandom_range(255));
        endcase
    endfunction

    task automatic random_config();
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        case ($urandom_range(19))
            0: w = '0;
            1: w = '1;
            2: w = COORD_W'($urandom_range(1, 65535));
            default: w = COORD_W'($urandom_range(1, 10));
        endcase
        case ($urandom_range(19))
            0: h = '0;
            1: h = '1;
            2: h = COORD_W'($urandom_range(1, 65535));
            3, 4: h = COORD_W'($urandom_range(21, 150));
            default: h = COORD_W'($urandom_range(1, 20));
        endcase
        if (h > 20 && $urandom_range(1) == 0) begin
            w = COORD_W'(1);
        end
        configure(w, h, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  PIX_W'($urandom_range(255)), random_mask(), random_mask());
    endtask

    // One frame, mostly well formed; sometimes cut short, overrun or noisy
    task automatic send_frame();
        longint     total;
        int         n;
        int         shape;
        int         i;
        logic       first;
        if (cfg_mirror.frame_width == 0) begin
            total = longint'(cfg_mirror.frame_height);
        end else begin
            total = longint'(cfg_mirror.frame_width) * longint'(cfg_mirror.frame_height);
        end
        n     = (total > FRAME_CAP) ? FRAME_CAP : int'(total);
        shape = $urandom_range(99);
        if (shape < 12 && n > 1) begin
            n = $urandom_range(1, n - 1);
        end else if (shape < 25 || n == 0) begin
            n = n + $urandom_range(1, 6);
        end
        // Stop at the end of the current idling phase
        if (n > push_limit - pix_pushed) begin
            n = push_limit - pix_pushed;
        end
        for (i = 0; i < n; i++) begin
            if (shape >= 90) begin
                first = ($urandom_range(7) == 0);
            end else begin
                first = (i == 0) && !(shape >= 25 && shape < 30);
            end
            push_pixel(random_pixel(), first);
        end
    endtask

    initial begin
        int  seg;
        int  i;
        bit  hold_done;

        hold_done             = 1'b0;
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        pix_ch.valid          = 1'b0;
        pix_ch.pixel_index    = '0;
        pix_ch.first_of_frame = 1'b0;
        place_ch.ready        = 1'b0;

        cfg_mirror.frame_width       = FRAME_WIDTH_RST;
        cfg_mirror.frame_height      = FRAME_HEIGHT_RST;
        cfg_mirror.interlace_on      = 1'b0;
        cfg_mirror.transparency_on   = 1'b0;
        cfg_mirror.transparent_index = '0;
        cfg_mirror.mask_clear_value  = MASK_CLEAR_RST;
        cfg_mirror.mask_opaque_value = MASK_OPAQUE_RST;
        pos_column = '0;
        pos_line   = '0;
        pos_row    = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one-pixel frame, the second pixel overflows
        push_pixel(8'h00, 1'b1);
        push_pixel(8'hFF, 1'b0);

        // Transparent and opaque pixels, then past the last line
        configure(16'd3, 16'd2, 1'b0, 1'b1, 8'hAB, 8'h00, 8'hFF);
        push_pixel(8'hAB, 1'b1);
        push_pixel(8'h00, 1'b0);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'hAB, 1'b0);
        push_pixel(8'h55, 1'b0);
        push_pixel(8'hAA, 1'b0);
        push_pixel(8'h12, 1'b0);

        // Interlace over nine lines walks all four passes
        configure(16'd1, 16'd9, 1'b1, 1'b0, 8'h00, 8'hFF, 8'h00);
        for (i = 0; i < 9; i++) begin
            push_pixel(PIX_W'($urandom_range(255)), i == 0);
        end

        // Zero width: every pixel starts a new line
        configure(16'd0, 16'd3, 1'b0, 1'b1, 8'h00, 8'h5A, 8'hA5);
        push_pixel(8'h00, 1'b1);
        push_pixel(8'h80, 1'b0);
        push_pixel(8'h00, 1'b0);

        // Zero height: every pixel overflows
        configure(16'hFFFF, 16'd0, 1'b0, 1'b0, 8'hFF, 8'h00, 8'hFF);
        push_pixel(8'h7F, 1'b1);
        push_pixel(8'hFE, 1'b0);

        // Widest and tallest frame
        configure(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'h01);
        push_pixel(8'hFF, 1'b1);
        push_pixel(8'h01, 1'b0);

        // Random phases: new settings, then a few frames
        while (pix_pushed < TOTAL_PIX) begin
            wait_drained();
            seg        = (pix_pushed * 3) / TOTAL_PIX;
            push_limit = ((seg + 1) * TOTAL_PIX + 2) / 3;
            if (seg == 0) begin
                src_idle_pct  = 21;
                sink_idle_pct = 71;
            end else if (seg == 1) begin
                src_idle_pct  = 71;
                sink_idle_pct = 21;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (seg == 2 && !hold_done) begin
                // Long output stall while 150 pixels of a 16 by 12 frame keep coming
                configure(16'd16, 16'd12, 1'($urandom_range(1)), 1'b1,
                          PIX_W'($urandom_range(255)), random_mask(), random_mask());
                hold_done     = 1'b1;
                sink_hold_req = 1'b1;
                for (i = 0; i < 150; i++) begin
                    push_pixel(random_pixel(), i == 0);
                end
            end else begin
                random_config();
                repeat ($urandom_range(1, 4)) begin
                    if (pix_pushed < push_limit) begin
                        send_frame();
                    end
                end
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("gif_pixel_placement_core regression: pass");
        end else begin
            $display("gif_pixel_placement_core regression: fail");
        end
        $finish;
    end

endmodule
